// ----- rtl/core/farc_pkg.sv -----
package farc_pkg;

	// fixed widths of the item and register words
	localparam int CMD_W      = 1;
	localparam int KEY_W      = 16;
	localparam int WORD_W     = 64;
	localparam int TOTAL_W    = 32;
	localparam int SLOTS_W    = 11;

	localparam logic [CMD_W-1:0]   CMD_GET = 1'b0;
	localparam logic [CMD_W-1:0]   CMD_PUT = 1'b1;
	localparam logic [SLOTS_W-1:0] ACTIVE_SLOTS_RESET = 11'd1024;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_GET_CNT,
		ST_PUT_CHK,
		ST_PUT_CMP,
		ST_PUT_EVICT,
		ST_PUT_SET,
		ST_OUT
	} farc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic get_upd;
		logic put_chk;
		logic put_cmp;
		logic evict;
		logic set;
		logic load_out;
	} farc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic is_put;
		logic in_range;
		logic slot_valid;
		logic take;
		logic out_free;
	} farc_stat_t;

endpackage

// ----- rtl/core/farc_ram.sv -----
module farc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/farc_ctrl.sv -----
module farc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  farc_pkg::farc_stat_t stat,
	output farc_pkg::farc_cmd_t  cmd
);
	import farc_pkg::*;

	farc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (!stat.in_range) begin
					state_d = ST_OUT;
				end else if (stat.is_put) begin
					state_d = ST_PUT_CHK;
				end else begin
					state_d = ST_GET_CNT;
				end
			end
			ST_GET_CNT: begin
				cmd.get_upd = 1'b1;
				state_d     = ST_OUT;
			end
			ST_PUT_CHK: begin
				cmd.put_chk = 1'b1;
				state_d     = stat.slot_valid ? ST_PUT_CMP : ST_PUT_SET;
			end
			ST_PUT_CMP: begin
				cmd.put_cmp = 1'b1;
				state_d     = stat.take ? ST_PUT_EVICT : ST_OUT;
			end
			ST_PUT_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_PUT_SET;
			end
			ST_PUT_SET: begin
				cmd.set = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/farc_dp.sv -----
module farc_dp #(
	parameter int NUM_KEYS    = 65536,
	parameter int NUM_SLOTS   = 1024,
	parameter int DATA_WIDTH  = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  farc_pkg::farc_cmd_t               cmd,
	output farc_pkg::farc_stat_t              stat,
	input  logic [farc_pkg::CMD_W-1:0]        command,
	input  logic [farc_pkg::KEY_W-1:0]        key,
	input  logic [farc_pkg::WORD_W-1:0]       data_in,
	input  logic                              cfg_write,
	input  logic [farc_pkg::SLOTS_W-1:0]      active_slots,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [farc_pkg::WORD_W-1:0]       data_out,
	output logic                              stored,
	output logic [farc_pkg::TOTAL_W-1:0]      hit_total,
	output logic [farc_pkg::TOTAL_W-1:0]      miss_total
);
	import farc_pkg::*;

	localparam int KW        = $clog2(NUM_KEYS);
	localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CLR_DEPTH = (NUM_KEYS > NUM_SLOTS) ? NUM_KEYS : NUM_SLOTS;
	localparam int CLW       = $clog2(CLR_DEPTH);
	localparam int NW        = SW + 1;

	// latched item
	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] data_q;

	// per-item working registers
	logic [SW-1:0]          slot_q;
	logic [KW-1:0]          res_key_q;
	logic [COUNT_WIDTH-1:0] cnt_k_q;
	logic                   hit_q;
	logic                   stored_q;

	logic [SW-1:0]      ptr_q;
	logic [SLOTS_W-1:0] active_slots_q;
	logic [CLW-1:0]     clr_q;

	logic [TOTAL_W-1:0] hits_q, misses_q;

	// memory ports
	logic                   cnt_we, cnt_re;
	logic [KW-1:0]          cnt_waddr, cnt_raddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
	logic                   ksm_we;
	logic [KW-1:0]          ksm_waddr;
	logic [SW:0]            ksm_wdata, ksm_rdata;
	logic                   skm_we;
	logic [SW-1:0]          skm_waddr;
	logic [KW:0]            skm_wdata, skm_rdata;
	logic                   pay_we;
	logic [DATA_WIDTH-1:0]  pay_rdata;

	logic [31:0]        key_ext;
	logic [KW-1:0]      kidx;
	logic               in_range;
	logic [16:0]        slots_ext, n17;
	logic [NW-1:0]      n_eff;
	logic [SW-1:0]      slot_cur;
	logic [NW-1:0]      slot_inc;
	logic [SW-1:0]      ptr_next;
	logic [CLW:0]       clr_ext;
	logic               clr_key_ok, clr_slot_ok;
	logic [COUNT_WIDTH-1:0] cnt_sat;

	assign key_ext  = {16'd0, key_q};
	assign kidx     = key_ext[KW-1:0];
	assign in_range = key_ext < 32'(NUM_KEYS);

	// effective ring length: zero acts as one, clipped to the slot count
	assign slots_ext = 17'(active_slots_q);
	assign n17 = (slots_ext == 17'd0) ? 17'd1 :
		((slots_ext > 17'(NUM_SLOTS)) ? 17'(NUM_SLOTS) : slots_ext);
	assign n_eff    = n17[NW-1:0];
	assign slot_cur = ({1'b0, ptr_q} >= n_eff) ? '0 : ptr_q;
	assign slot_inc = {1'b0, slot_q} + NW'(1);
	assign ptr_next = (slot_inc >= n_eff) ? '0 : slot_inc[SW-1:0];

	assign clr_ext     = {1'b0, clr_q};
	assign clr_key_ok  = clr_ext < (CLW+1)'(NUM_KEYS);
	assign clr_slot_ok = clr_ext < (CLW+1)'(NUM_SLOTS);

	assign cnt_sat = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);

	// request counters
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = kidx;
		cnt_wdata = cnt_sat;
		if (cmd.clear) begin
			cnt_we    = clr_key_ok;
			cnt_waddr = clr_q[KW-1:0];
			cnt_wdata = '0;
		end else if (cmd.get_upd) begin
			cnt_we = 1'b1;
		end
	end
	assign cnt_re    = cmd.lookup | cmd.put_chk;
	assign cnt_raddr = cmd.put_chk ? skm_rdata[KW-1:0] : kidx;

	// key -> slot map, {valid, slot}
	always_comb begin
		ksm_we    = 1'b0;
		ksm_waddr = kidx;
		ksm_wdata = {1'b1, slot_q};
		if (cmd.clear) begin
			ksm_we    = clr_key_ok;
			ksm_waddr = clr_q[KW-1:0];
			ksm_wdata = '0;
		end else if (cmd.evict) begin
			ksm_we    = 1'b1;
			ksm_waddr = res_key_q;
			ksm_wdata = '0;
		end else if (cmd.set) begin
			ksm_we = 1'b1;
		end
	end

	// slot -> key map, {valid, key}
	always_comb begin
		skm_we    = 1'b0;
		skm_waddr = slot_q;
		skm_wdata = {1'b1, kidx};
		if (cmd.clear) begin
			skm_we    = clr_slot_ok;
			skm_waddr = clr_q[SW-1:0];
			skm_wdata = '0;
		end else if (cmd.set) begin
			skm_we = 1'b1;
		end
	end

	assign pay_we = cmd.set;

	farc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_KEYS), .AW(KW)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	farc_ram #(.WIDTH(SW+1), .DEPTH(NUM_KEYS), .AW(KW)) u_ksm_ram (
		.clk   (clk),
		.we    (ksm_we),
		.waddr (ksm_waddr),
		.wdata (ksm_wdata),
		.re    (cmd.lookup),
		.raddr (kidx),
		.rdata (ksm_rdata)
	);

	farc_ram #(.WIDTH(KW+1), .DEPTH(NUM_SLOTS), .AW(SW)) u_skm_ram (
		.clk   (clk),
		.we    (skm_we),
		.waddr (skm_waddr),
		.wdata (skm_wdata),
		.re    (cmd.lookup),
		.raddr (slot_cur),
		.rdata (skm_rdata)
	);

	farc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_SLOTS), .AW(SW)) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (slot_q),
		.wdata (data_q),
		.re    (cmd.get_upd),
		.raddr (ksm_rdata[SW-1:0]),
		.rdata (pay_rdata)
	);

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= command;
			key_q  <= key;
			data_q <= data_in[DATA_WIDTH-1:0];
		end
		if (cmd.lookup) begin
			slot_q <= slot_cur;
		end
		if (cmd.put_chk) begin
			cnt_k_q   <= cnt_rdata;
			res_key_q <= skm_rdata[KW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= ACTIVE_SLOTS_RESET;
			ptr_q          <= '0;
			clr_q          <= '0;
			hit_q          <= 1'b0;
			stored_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				active_slots_q <= active_slots;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (cmd.accept) begin
				hit_q    <= 1'b0;
				stored_q <= 1'b0;
			end
			// a put first folds the pointer back, taken or not
			if (cmd.lookup && cmd_q == CMD_PUT && in_range) begin
				ptr_q <= slot_cur;
			end
			if (cmd.get_upd) begin
				hit_q <= ksm_rdata[SW];
			end
			if (cmd.set) begin
				ptr_q    <= ptr_next;
				stored_q <= 1'b1;
			end
		end
	end

	// result register and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			hits_q    <= '0;
			misses_q  <= '0;
		end else begin
			if (cmd.load_out) begin
				out_valid <= 1'b1;
				if (cmd_q == CMD_GET) begin
					if (hit_q) begin
						hits_q <= (&hits_q) ? hits_q : hits_q + TOTAL_W'(1);
					end else begin
						misses_q <= (&misses_q) ? misses_q : misses_q + TOTAL_W'(1);
					end
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit      <= hit_q;
			stored   <= stored_q;
			data_out <= hit_q ? WORD_W'(pay_rdata) : '0;
		end
	end

	assign hit_total  = hits_q;
	assign miss_total = misses_q;

	assign stat.clear_last = clr_q == CLW'(CLR_DEPTH - 1);
	assign stat.is_put     = cmd_q == CMD_PUT;
	assign stat.in_range   = in_range;
	assign stat.slot_valid = skm_rdata[KW];
	assign stat.take       = cnt_k_q > cnt_rdata;
	assign stat.out_free   = !out_valid || !out_stall;

	a_stored_is_put: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q |-> cmd_q == CMD_PUT)
		else $error("store flagged for a get");

	a_hit_is_get: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> cmd_q == CMD_GET)
		else $error("hit flagged for a put");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set |=> {1'b0, ptr_q} < n_eff)
		else $error("ring pointer past active slots after insert");

	a_hits_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> hits_q >= $past(hits_q) && misses_q >= $past(misses_q))
		else $error("running total went backward");

endmodule

// ----- rtl/core/frequency_admission_ring_cache_unit.sv -----
// Keyed cache with a ring of payload slots and admission by request count.
//
// Input channel: in_valid / in_stall carry one word {command, key, data_in}.
//   command get looks the key up and bumps its saturating request counter;
//   command put offers data_in for the slot under the ring pointer, taken when
//   the slot is empty or the key's count is strictly above the resident's.
// Output channel: out_valid / out_stall, one result word per input word:
//   hit, data_out, stored and the saturating hit_total / miss_total.
// Config channel: cfg_valid / cfg_ready writes active_slots (ring length);
//   write it only while no item is in flight.
// Sequence: one item at a time through a four-memory datapath with
//   registered reads. A get reads the key's counter, then writes it and
//   reads the payload; an out-of-range key goes straight to the result; a
//   put reads the slot owner, then the resident's count if one is held, and
//   on admission makes the eviction write if needed, then the map and
//   payload write; the one write port of the key-slot map keeps them apart.
// Reset: the key maps and request counters are cleared by a sweep over
//   max(NUM_KEYS, NUM_SLOTS) entries (65536 by default); in_stall stays high.
// A stalled result sits in the output register; the next word is accepted
//   meanwhile and waits before its own result stage until the register drains.
module frequency_admission_ring_cache_unit #(
	parameter int NUM_KEYS    = 65536,
	parameter int NUM_SLOTS   = 1024,
	parameter int DATA_WIDTH  = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [farc_pkg::CMD_W-1:0]   command,
	input  logic [farc_pkg::KEY_W-1:0]   key,
	input  logic [farc_pkg::WORD_W-1:0]  data_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [farc_pkg::WORD_W-1:0]  data_out,
	output logic                         stored,
	output logic [farc_pkg::TOTAL_W-1:0] hit_total,
	output logic [farc_pkg::TOTAL_W-1:0] miss_total,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [farc_pkg::SLOTS_W-1:0] active_slots
);
	import farc_pkg::*;

	farc_cmd_t  cmd;
	farc_stat_t stat;

	// the register is taken whenever offered; software keeps writes to idle
	assign cfg_ready = 1'b1;

	farc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	farc_dp #(
		.NUM_KEYS    (NUM_KEYS),
		.NUM_SLOTS   (NUM_SLOTS),
		.DATA_WIDTH  (DATA_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.key          (key),
		.data_in      (data_in),
		.cfg_write    (cfg_valid & cfg_ready),
		.active_slots (active_slots),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.data_out     (data_out),
		.stored       (stored),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

endmodule
